FILE: design/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types and constants for the servo step PWM controller: register
// indexes, reset values, command characters and the result record.
// ----------------------------------------------------------------------------
package sspc_pkg;

  // Default width of the tick counter inside a frame.
  localparam int TICK_COUNT_WIDTH = 12;

  // Configuration port geometry.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 12;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_WIDTH = 8;
  localparam int M_TDATA_WIDTH = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STEP_LENGTH   = 3'd0,
    REG_HOME_POSITION = 3'd1,
    REG_UPPER_GUARD   = 3'd2,
    REG_LOWER_GUARD   = 3'd3,
    REG_FRAME_TICKS   = 3'd4,
    REG_FRAME_REPEATS = 3'd5
  } cfg_reg_t;

  // Kind of an input item.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CMD  = 1'b1
  } op_t;

  // Register reset values.
  localparam logic [5:0]  STEP_LENGTH_RESET   = 6'd5;
  localparam logic [7:0]  HOME_POSITION_RESET = 8'd52;
  localparam logic [7:0]  UPPER_GUARD_RESET   = 8'd92;
  localparam logic [7:0]  LOWER_GUARD_RESET   = 8'd17;
  localparam logic [11:0] FRAME_TICKS_RESET   = 12'd1500;
  localparam logic [3:0]  FRAME_REPEATS_RESET = 4'd7;

  // Command characters.
  localparam logic [7:0] CHAR_LEFT  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_RIGHT = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_HOME  = 8'h68;  // 'h'

  // Configuration register set.
  typedef struct packed {
    logic [5:0]  step_length;
    logic [7:0]  home_position;
    logic [7:0]  upper_guard;
    logic [7:0]  lower_guard;
    logic [11:0] frame_ticks;
    logic [3:0]  frame_repeats;
  } cfg_t;

  // One result item; packs as m_tdata[9:0] from the highest bit down.
  typedef struct packed {
    logic [7:0] servo_position;
    logic       busy_res;
    logic       pulse_level;
  } result_t;

endpackage

FILE: design/sspc_core.sv
// ----------------------------------------------------------------------------
// sspc_core
// Servo position and frame burst state with its update for one
// tick or command item, and the result that item produces.
// ----------------------------------------------------------------------------
module sspc_core #(
  parameter int TICK_COUNT_WIDTH = sspc_pkg::TICK_COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  sspc_pkg::cfg_t    cfg,
  input  logic              step_en,
  input  sspc_pkg::op_t     op,
  input  logic [7:0]        cmd_byte,
  output sspc_pkg::result_t result
);

  // Compare width wide enough for the counter and the frame length plus one.
  localparam int CW = ((TICK_COUNT_WIDTH > 12) ? TICK_COUNT_WIDTH : 12) + 1;

  logic [7:0]                  position_reg, position_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [3:0]                  frame_count, frame_count_next;
  logic                        burst_active, burst_active_next;

  logic [CW-1:0] tick_inc;
  logic          frame_end;
  logic          burst_end;
  logic [8:0]    pos_sum;
  logic [7:0]    pos_left;
  logic [7:0]    pos_right;
  logic          level_cur;
  logic          level_new;

  // Frame and burst end conditions for a tick.
  always_comb begin
    tick_inc  = CW'(tick_count) + CW'(1);
    frame_end = (tick_inc >= CW'(cfg.frame_ticks)) || (tick_count == '1);
    burst_end = (({1'b0, frame_count} + 5'd1) >= {1'b0, cfg.frame_repeats})
                || (frame_count == 4'hF);
  end

  // Candidate positions for the turn commands, saturated at both ends.
  always_comb begin
    pos_sum   = {1'b0, position_reg} + {3'b000, cfg.step_length};
    pos_left  = pos_sum[8] ? 8'hFF : pos_sum[7:0];
    pos_right = (position_reg >= {2'b00, cfg.step_length})
                ? (position_reg - {2'b00, cfg.step_length}) : 8'h00;
  end

  // Next state for the item on the input.
  always_comb begin
    position_next     = position_reg;
    tick_count_next   = tick_count;
    frame_count_next  = frame_count;
    burst_active_next = burst_active;
    case (op)
      sspc_pkg::OP_TICK: begin
        if (burst_active) begin
          if (frame_end) begin
            tick_count_next = '0;
            if (burst_end) begin
              frame_count_next  = '0;
              burst_active_next = 1'b0;
            end else begin
              frame_count_next = frame_count + 4'd1;
            end
          end else begin
            tick_count_next = tick_inc[TICK_COUNT_WIDTH-1:0];
          end
        end
      end
      sspc_pkg::OP_CMD: begin
        // A command is taken only between bursts and always restarts one.
        if (!burst_active) begin
          if (cmd_byte == sspc_pkg::CHAR_LEFT && position_reg < cfg.upper_guard) begin
            position_next = pos_left;
          end
          if (cmd_byte == sspc_pkg::CHAR_RIGHT && position_reg > cfg.lower_guard) begin
            position_next = pos_right;
          end
          if (cmd_byte == sspc_pkg::CHAR_HOME) begin
            position_next = cfg.home_position;
          end
          tick_count_next   = '0;
          frame_count_next  = '0;
          burst_active_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Line level: a tick reports the level during it, a command the level after.
  always_comb begin
    level_cur = burst_active && (tick_count < TICK_COUNT_WIDTH'(position_reg));
    level_new = burst_active_next
                && (tick_count_next < TICK_COUNT_WIDTH'(position_next));
    result.pulse_level    = (op == sspc_pkg::OP_TICK) ? level_cur : level_new;
    result.busy_res       = burst_active_next;
    result.servo_position = position_next;
  end

  // State registers; reset starts a burst at the home position.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg <= sspc_pkg::HOME_POSITION_RESET;
      tick_count   <= '0;
      frame_count  <= '0;
      burst_active <= 1'b1;
    end else if (step_en) begin
      position_reg <= position_next;
      tick_count   <= tick_count_next;
      frame_count  <= frame_count_next;
      burst_active <= burst_active_next;
    end
  end

endmodule

FILE: design/servo_step_pwm_controller.sv
// ----------------------------------------------------------------------------
// servo_step_pwm_controller
// Hobby-servo pulse generator stepped by tick items and command bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transfer: s_tuser selects a time
//   tick (0) or a command byte (1), and s_tdata holds the byte. Every item
//   gives exactly one result item on the master stream: the servo line level,
//   the burst-running flag and the current position.
//   An item passes an input register and then a result register. One item
//   is taken every cycle while the receiver does not stall; the state update
//   is a single counter and compare step.
//   When the receiver stalls, the result register holds its item, the input
//   register still takes an item if it is empty, and s_tready falls once it
//   is full; nothing is lost or repeated.
//   Reset clears both stream registers, loads the register reset values and
//   starts a burst of frames at the home position.
//   Configuration registers are written through cfg_we, cfg_index and
//   cfg_data, and are only to be written while no item is in flight.
// ----------------------------------------------------------------------------
module servo_step_pwm_controller #(
  parameter int TICK_COUNT_WIDTH = sspc_pkg::TICK_COUNT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [sspc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [sspc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  // Slave stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [sspc_pkg::S_TDATA_WIDTH-1:0]    s_tdata,  // [7:0] cmd_byte
  input  logic                                  s_tuser,  // [0] op
  // Master stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [sspc_pkg::M_TDATA_WIDTH-1:0]    m_tdata   // [0] pulse_level,
                                                          // [1] busy_res,
                                                          // [9:2] servo_position
);

  sspc_pkg::cfg_t    cfg;
  logic              in_valid;
  sspc_pkg::op_t     in_op;
  logic [7:0]        in_cmd;
  logic              out_valid;
  sspc_pkg::result_t out_data;
  sspc_pkg::result_t result;
  logic              advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_length   <= sspc_pkg::STEP_LENGTH_RESET;
      cfg.home_position <= sspc_pkg::HOME_POSITION_RESET;
      cfg.upper_guard   <= sspc_pkg::UPPER_GUARD_RESET;
      cfg.lower_guard   <= sspc_pkg::LOWER_GUARD_RESET;
      cfg.frame_ticks   <= sspc_pkg::FRAME_TICKS_RESET;
      cfg.frame_repeats <= sspc_pkg::FRAME_REPEATS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sspc_pkg::REG_STEP_LENGTH:   cfg.step_length   <= cfg_data[5:0];
        sspc_pkg::REG_HOME_POSITION: cfg.home_position <= cfg_data[7:0];
        sspc_pkg::REG_UPPER_GUARD:   cfg.upper_guard   <= cfg_data[7:0];
        sspc_pkg::REG_LOWER_GUARD:   cfg.lower_guard   <= cfg_data[7:0];
        sspc_pkg::REG_FRAME_TICKS:   cfg.frame_ticks   <= cfg_data[11:0];
        sspc_pkg::REG_FRAME_REPEATS: cfg.frame_repeats <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the result register is free or drains.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= sspc_pkg::op_t'(s_tuser);
      in_cmd <= s_tdata[7:0];
    end
  end

  // State update for the registered item.
  sspc_core #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step_en  (advance),
    .op       (in_op),
    .cmd_byte (in_cmd),
    .result   (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = sspc_pkg::M_TDATA_WIDTH'(out_data);

endmodule

FILE: design/sspc_checker.sv
// ----------------------------------------------------------------------------
// sspc_checker
// Port-level checks for the servo step PWM controller, bound to the top level.
// ----------------------------------------------------------------------------
module sspc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [sspc_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // The handshake outputs always carry a defined level once out of reset.
  a_known_hs: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tready, m_tvalid}))
    else $error("handshake output unknown");

  // A draining receiver always leaves room for a new item.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // An accepted item with an empty pipe gives a result once it has passed the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid && m_tready) |=> ##1 m_tvalid)
    else $error("result missing after accepted item");

  // The unused top bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:10] == 6'd0))
    else $error("result padding not zero");

endmodule

bind servo_step_pwm_controller sspc_checker u_sspc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
